FILE: rtl/pbts_pkg.sv
// Shared types, codes and defaults of the bitmap priority task scheduler.
package pbts_pkg;

  localparam int TASK_SLOTS_DEF  = 16;
  localparam int PRIO_LEVELS_DEF = 32;

  localparam logic       SCHED_EN_RST = 1'b1;
  localparam logic [7:0] SLICE_RST    = 8'd10;
  localparam logic [4:0] IDLE_PRIO_RST = 5'd31;

  typedef enum logic [3:0] {
    OP_TICK     = 4'd0,
    OP_YIELD    = 4'd1,
    OP_CREATE   = 4'd2,
    OP_TERM     = 4'd3,
    OP_BLOCK    = 4'd4,
    OP_UNBLOCK  = 4'd5,
    OP_SLEEP    = 4'd6,
    OP_DEADLINE = 4'd7,
    OP_BOOST    = 4'd8,
    OP_RESTORE  = 4'd9
  } op_e;

  typedef enum logic [2:0] {
    SL_UNUSED   = 3'd0,
    SL_READY    = 3'd1,
    SL_RUNNING  = 3'd2,
    SL_BLOCKED  = 3'd3,
    SL_SLEEPING = 3'd4
  } slot_e;

  typedef enum logic [1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_EDF  = 2'd2
  } pol_e;

  typedef enum logic [1:0] {
    STS_OK     = 2'd0,
    STS_NOSLOT = 2'd1,
    STS_BADTSK = 2'd2
  } sts_e;

  typedef enum logic [1:0] {
    CFG_SCHED_EN  = 2'd0,
    CFG_SLICE     = 2'd1,
    CFG_IDLE_PRIO = 2'd2
  } cfg_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_TIME,
    SQ_SEL,
    SQ_PICK,
    SQ_FINAL,
    SQ_DONE
  } seq_e;

  typedef struct packed {
    logic [3:0]  opcode;
    logic [3:0]  task_id;
    logic [4:0]  priority_req;
    logic [1:0]  policy;
    logic [31:0] amount;
    logic [31:0] period_len;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  result_task;
    logic        switched;
    logic [3:0]  prior_task;
    logic        resched_needed;
    logic [15:0] miss_mask;
    logic        none_ready;
  } rsp_t;

  typedef struct packed {
    logic in_fire;
    logic pass_go;
    logic out_free;
  } seq_in_t;

  typedef struct packed {
    logic        is_edf;
    logic        in_use;
    logic        sleeping;
    logic [31:0] due;
    logic [31:0] period;
    logic [31:0] wake;
  } tm_in_t;

  typedef struct packed {
    logic        miss;
    logic [31:0] due_next;
    logic        wake_hit;
  } tm_out_t;

endpackage

FILE: rtl/pbts_time_unit.sv
// Shared per-slot deadline and wakeup evaluator used by the slot sweep.
module pbts_time_unit (
  input  logic [31:0]      now_i,
  input  pbts_pkg::tm_in_t slot_i,
  output pbts_pkg::tm_out_t res_o
);

  logic miss;

  assign miss = slot_i.is_edf && slot_i.in_use && (slot_i.due != 32'd0) &&
                (now_i > slot_i.due);

  always_comb begin
    res_o.miss     = miss;
    res_o.due_next = (miss && slot_i.period != 32'd0) ? slot_i.due + slot_i.period
                                                      : slot_i.due;
    res_o.wake_hit = slot_i.sleeping && (now_i >= slot_i.wake);
  end

endmodule

FILE: rtl/pbts_seq.sv
// Operation sequencer: state machine and slot sweep counter.
module pbts_seq #(
  parameter int TASK_SLOTS = pbts_pkg::TASK_SLOTS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pbts_pkg::seq_in_t         ctl_i,
  output pbts_pkg::seq_e            state_o,
  output logic [$clog2(TASK_SLOTS)-1:0] idx_o
);

  localparam int IW = $clog2(TASK_SLOTS);

  pbts_pkg::seq_e state_q, state_d;
  logic [IW-1:0]  idx_q, idx_d;
  logic           last;

  assign last    = (idx_q == IW'(TASK_SLOTS - 1));
  assign state_o = state_q;
  assign idx_o   = idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbts_pkg::SQ_IDLE;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
    end
  end

  always_comb begin
    state_d = state_q;
    idx_d   = idx_q;
    case (state_q)
      pbts_pkg::SQ_IDLE: begin
        if (ctl_i.in_fire) state_d = pbts_pkg::SQ_EXEC;
      end
      pbts_pkg::SQ_EXEC: begin
        idx_d   = '0;
        state_d = ctl_i.pass_go ? pbts_pkg::SQ_TIME : pbts_pkg::SQ_FINAL;
      end
      pbts_pkg::SQ_TIME: begin
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = pbts_pkg::SQ_SEL;
      end
      pbts_pkg::SQ_SEL: begin
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = pbts_pkg::SQ_PICK;
      end
      pbts_pkg::SQ_PICK: begin
        idx_d   = '0;
        state_d = pbts_pkg::SQ_FINAL;
      end
      pbts_pkg::SQ_FINAL: begin
        idx_d = last ? '0 : idx_q + 1'b1;
        if (last) state_d = pbts_pkg::SQ_DONE;
      end
      pbts_pkg::SQ_DONE: begin
        if (ctl_i.out_free) state_d = pbts_pkg::SQ_IDLE;
      end
      default: state_d = pbts_pkg::SQ_IDLE;
    endcase
  end

endmodule

FILE: rtl/priority_bitmap_task_scheduler_unit.sv
// Top level of the bitmap priority task scheduler: slot table, run order, result register.
//
//  channel | direction | handshake                 | payload
//  in      | request   | in_valid_i / in_ready_o   | in_req_i  (pbts_pkg::req_t)
//  out     | response  | out_valid_o / out_ready_i | out_rsp_o (pbts_pkg::rsp_t)
//  cfg     | write     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
// Flow: one request at a time. An operation without a scheduling pass runs only the
// final priority check sweep before its response; one with a pass first runs the
// deadline/wake sweep, the best pick sweep and the pick itself. Each sweep visits
// one slot per cycle.
// Reset: slot 0 running at idle priority, all other slots unused.
// Stalls: a finished result waits in the sequencer until the output register is
// free; a new request is taken while the previous response still waits there.
// Config writes are taken only while idle.
module priority_bitmap_task_scheduler_unit #(
  parameter int TASK_SLOTS  = pbts_pkg::TASK_SLOTS_DEF,
  parameter int PRIO_LEVELS = pbts_pkg::PRIO_LEVELS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pbts_pkg::req_t in_req_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output pbts_pkg::rsp_t out_rsp_o,
  input  logic           cfg_valid_i,
  output logic           cfg_ready_o,
  input  logic [1:0]     cfg_index_i,
  input  logic [7:0]     cfg_data_i
);

  localparam int TW = $clog2(TASK_SLOTS);   // slot index width, also run-order rank
  localparam int PW = $clog2(PRIO_LEVELS);

  // Clamp a requested priority to the implemented range.
  function automatic logic [PW-1:0] clamp_prio(input logic [4:0] p);
    logic [8:0] pe;
    pe = {4'b0, p};
    if (pe >= 9'(PRIO_LEVELS)) return PW'(PRIO_LEVELS - 1);
    else                       return pe[PW-1:0];
  endfunction

  // Slot table. Ready tasks keep a rank: 0 is the newest in the run order,
  // so the head of a level is the ready task there with the largest rank.
  pbts_pkg::slot_e st_q   [TASK_SLOTS];
  pbts_pkg::slot_e st_d   [TASK_SLOTS];
  logic [PW-1:0]   base_q [TASK_SLOTS];
  logic [PW-1:0]   base_d [TASK_SLOTS];
  logic [PW-1:0]   eff_q  [TASK_SLOTS];
  logic [PW-1:0]   eff_d  [TASK_SLOTS];
  logic [1:0]      pol_q  [TASK_SLOTS];
  logic [1:0]      pol_d  [TASK_SLOTS];
  logic [7:0]      left_q [TASK_SLOTS];
  logic [7:0]      left_d [TASK_SLOTS];
  logic [7:0]      full_q [TASK_SLOTS];
  logic [7:0]      full_d [TASK_SLOTS];
  logic [31:0]     wake_q [TASK_SLOTS];
  logic [31:0]     wake_d [TASK_SLOTS];
  logic [31:0]     due_q  [TASK_SLOTS];
  logic [31:0]     due_d  [TASK_SLOTS];
  logic [31:0]     per_q  [TASK_SLOTS];
  logic [31:0]     per_d  [TASK_SLOTS];
  logic [TW-1:0]   rank_q [TASK_SLOTS];
  logic [TW-1:0]   rank_d [TASK_SLOTS];

  logic [TW-1:0] run_q, run_d;
  logic [31:0]   tick_q, tick_d;
  logic          en_q, en_d;
  logic [7:0]    slice_q, slice_d;

  // Per-request context
  pbts_pkg::req_t  req_q, req_d;
  logic [TW-1:0]   prior_q, prior_d;
  logic [1:0]      sts_q, sts_d;
  logic            made_v_q, made_v_d;
  logic [TW-1:0]   made_q, made_d;
  logic [TASK_SLOTS-1:0] miss_q, miss_d;
  logic            none_q, none_d;

  // Sweep best-candidate registers
  logic          bv_q, bv_d;
  logic [TW-1:0] bid_q, bid_d;
  logic [PW-1:0] bp_q, bp_d;
  logic [TW-1:0] br_q, br_d;

  logic           out_v_q, out_v_d;
  pbts_pkg::rsp_t out_q, out_d;

  // Run-order update requests
  logic          push_en, pull_en;
  logic [TW-1:0] push_id, pull_id;

  pbts_pkg::seq_e    sq;
  logic [TW-1:0]     idx;
  pbts_pkg::seq_in_t sq_in;
  logic              in_fire, cfg_fire, pass_go, out_free;

  pbts_pkg::tm_in_t  tm_in;
  pbts_pkg::tm_out_t tm_out;

  assign in_ready_o  = (sq == pbts_pkg::SQ_IDLE);
  assign cfg_ready_o = (sq == pbts_pkg::SQ_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_v_q || out_ready_i;
  assign out_valid_o = out_v_q;
  assign out_rsp_o   = out_q;

  assign sq_in.in_fire  = in_fire;
  assign sq_in.pass_go  = pass_go;
  assign sq_in.out_free = out_free;

  pbts_seq #(.TASK_SLOTS(TASK_SLOTS)) u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (sq_in),
    .state_o (sq),
    .idx_o   (idx)
  );

  always_comb begin
    tm_in.is_edf   = (pol_q[idx] == pbts_pkg::POL_EDF);
    tm_in.in_use   = (st_q[idx] != pbts_pkg::SL_UNUSED);
    tm_in.sleeping = (st_q[idx] == pbts_pkg::SL_SLEEPING);
    tm_in.due      = due_q[idx];
    tm_in.period   = per_q[idx];
    tm_in.wake     = wake_q[idx];
  end

  pbts_time_unit u_time (
    .now_i  (tick_q),
    .slot_i (tm_in),
    .res_o  (tm_out)
  );

  // Main next-state logic
  always_comb begin
    logic [6:0]    tid_ext;
    logic          tid_ok, tv;
    logic [TW-1:0] t, cur, nx, free_id;
    logic          free_v;
    logic [PW-1:0] preq, lvl, ip;
    logic [7:0]    lm;
    logic [1:0]    npol;
    logic          better, cbv;
    logic [TW+3:0] rt_ext, pr_ext;
    logic [TASK_SLOTS+15:0] mx;

    tid_ext = {3'b0, req_q.task_id};
    tid_ok  = tid_ext < 7'(TASK_SLOTS);
    t       = tid_ext[TW-1:0];
    tv      = tid_ok && (st_q[t] != pbts_pkg::SL_UNUSED);
    cur     = run_q;
    preq    = clamp_prio(req_q.priority_req);
    nx      = bid_q;
    lm      = '0;
    npol    = '0;
    lvl     = '0;
    ip      = '0;
    better  = 1'b0;
    cbv     = 1'b0;
    rt_ext  = '0;
    pr_ext  = '0;
    mx      = '0;

    free_v  = 1'b0;
    free_id = '0;
    for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
      if (st_q[i] == pbts_pkg::SL_UNUSED) begin
        free_v  = 1'b1;
        free_id = TW'(i);
      end
    end

    st_d   = st_q;   base_d = base_q; eff_d  = eff_q;  pol_d = pol_q;
    left_d = left_q; full_d = full_q; wake_d = wake_q; due_d = due_q;
    per_d  = per_q;
    run_d  = run_q;  tick_d = tick_q; en_d = en_q; slice_d = slice_q;
    req_d  = req_q;  prior_d = prior_q; sts_d = sts_q;
    made_v_d = made_v_q; made_d = made_q; miss_d = miss_q; none_d = none_q;
    bv_d = bv_q; bid_d = bid_q; bp_d = bp_q; br_d = br_q;
    out_v_d = out_v_q && !out_ready_i;
    out_d   = out_q;
    push_en = 1'b0; push_id = '0;
    pull_en = 1'b0; pull_id = '0;
    pass_go = 1'b0;

    case (sq)
      pbts_pkg::SQ_IDLE: begin
        if (cfg_fire) begin
          case (pbts_pkg::cfg_e'(cfg_index_i))
            pbts_pkg::CFG_SCHED_EN: en_d    = cfg_data_i[0];
            pbts_pkg::CFG_SLICE:    slice_d = cfg_data_i;
            pbts_pkg::CFG_IDLE_PRIO: begin
              if (st_q[0] != pbts_pkg::SL_UNUSED) begin
                ip        = clamp_prio(cfg_data_i[4:0]);
                base_d[0] = ip;
                eff_d[0]  = ip;
                if (st_q[0] == pbts_pkg::SL_READY) begin
                  pull_en = 1'b1; pull_id = '0;
                  push_en = 1'b1; push_id = '0;
                end
              end
            end
            default: ;
          endcase
        end
        if (in_fire) begin
          req_d    = in_req_i;
          prior_d  = run_q;
          sts_d    = pbts_pkg::STS_OK;
          made_v_d = 1'b0;
          miss_d   = '0;
          none_d   = 1'b0;
        end
      end

      pbts_pkg::SQ_EXEC: begin
        case (pbts_pkg::op_e'(req_q.opcode))
          pbts_pkg::OP_TICK, pbts_pkg::OP_YIELD: begin
            if (req_q.opcode == pbts_pkg::OP_TICK) tick_d = tick_q + 32'd1;
            pass_go = en_q;
            // round-robin slice countdown of the running task
            if (en_q && st_q[cur] == pbts_pkg::SL_RUNNING && pol_q[cur] == pbts_pkg::POL_RR) begin
              lm = (left_q[cur] != 8'd0) ? left_q[cur] - 8'd1 : 8'd0;
              if (lm == 8'd0) begin
                left_d[cur] = full_q[cur];
                st_d[cur]   = pbts_pkg::SL_READY;
                push_en = 1'b1; push_id = cur;
              end else begin
                left_d[cur] = lm;
              end
            end
          end
          pbts_pkg::OP_CREATE: begin
            if (!free_v) begin
              sts_d = pbts_pkg::STS_NOSLOT;
            end else begin
              npol = (req_q.policy == 2'd3) ? pbts_pkg::POL_FIFO : req_q.policy;
              made_v_d        = 1'b1;
              made_d          = free_id;
              st_d[free_id]   = pbts_pkg::SL_READY;
              base_d[free_id] = preq;
              eff_d[free_id]  = preq;
              pol_d[free_id]  = npol;
              left_d[free_id] = (npol == pbts_pkg::POL_RR) ? slice_q : 8'd0;
              full_d[free_id] = (npol == pbts_pkg::POL_RR) ? slice_q : 8'd0;
              due_d[free_id]  = '0;
              per_d[free_id]  = '0;
              wake_d[free_id] = '0;
              push_en = 1'b1; push_id = free_id;
            end
          end
          pbts_pkg::OP_TERM: begin
            if (!tv) begin
              sts_d = pbts_pkg::STS_BADTSK;
            end else begin
              if (st_q[t] == pbts_pkg::SL_READY) begin
                pull_en = 1'b1; pull_id = t;
              end
              st_d[t] = pbts_pkg::SL_UNUSED;
              pass_go = (t == cur) && en_q;
            end
          end
          pbts_pkg::OP_BLOCK: begin
            if (!tv) begin
              sts_d = pbts_pkg::STS_BADTSK;
            end else begin
              if (st_q[t] == pbts_pkg::SL_READY) begin
                pull_en = 1'b1; pull_id = t;
              end
              st_d[t] = pbts_pkg::SL_BLOCKED;
            end
          end
          pbts_pkg::OP_UNBLOCK: begin
            if (!tv) begin
              sts_d = pbts_pkg::STS_BADTSK;
            end else if (st_q[t] == pbts_pkg::SL_BLOCKED) begin
              st_d[t] = pbts_pkg::SL_READY;
              push_en = 1'b1; push_id = t;
            end
          end
          pbts_pkg::OP_SLEEP: begin
            if (st_q[cur] != pbts_pkg::SL_RUNNING) begin
              sts_d = pbts_pkg::STS_BADTSK;
            end else begin
              st_d[cur]   = pbts_pkg::SL_SLEEPING;
              wake_d[cur] = tick_q + req_q.amount;
              pass_go     = en_q;
            end
          end
          pbts_pkg::OP_DEADLINE: begin
            if (!tv) begin
              sts_d = pbts_pkg::STS_BADTSK;
            end else begin
              due_d[t] = tick_q + req_q.amount;
              per_d[t] = req_q.period_len;
            end
          end
          pbts_pkg::OP_BOOST, pbts_pkg::OP_RESTORE: begin
            if (!tv) begin
              sts_d = pbts_pkg::STS_BADTSK;
            end else begin
              if (req_q.opcode == pbts_pkg::OP_BOOST) begin
                lvl    = preq;
                better = preq < eff_q[t];
              end else begin
                lvl    = (base_q[t] < preq) ? base_q[t] : preq;
                better = lvl != eff_q[t];
              end
              if (better) begin
                eff_d[t] = lvl;
                if (st_q[t] == pbts_pkg::SL_READY) begin
                  pull_en = 1'b1; pull_id = t;
                  push_en = 1'b1; push_id = t;
                end
              end
            end
          end
          default: ;
        endcase
      end

      pbts_pkg::SQ_TIME: begin
        if (tm_out.miss) miss_d[idx] = 1'b1;
        due_d[idx] = tm_out.due_next;
        if (tm_out.wake_hit) begin
          st_d[idx] = pbts_pkg::SL_READY;
          push_en = 1'b1; push_id = idx;
        end
      end

      pbts_pkg::SQ_SEL, pbts_pkg::SQ_FINAL: begin
        cbv    = (idx == '0) ? 1'b0 : bv_q;
        better = (st_q[idx] == pbts_pkg::SL_READY) &&
                 (!cbv || eff_q[idx] < bp_q ||
                  (eff_q[idx] == bp_q && rank_q[idx] > br_q));
        bv_d = cbv || better;
        if (better) begin
          bid_d = idx;
          bp_d  = eff_q[idx];
          br_d  = rank_q[idx];
        end
      end

      pbts_pkg::SQ_PICK: begin
        if (!bv_q) begin
          none_d = 1'b1;
        end else if (!(st_q[cur] == pbts_pkg::SL_RUNNING && eff_q[cur] <= eff_q[nx])) begin
          if (st_q[cur] == pbts_pkg::SL_RUNNING) begin
            st_d[cur] = pbts_pkg::SL_READY;
            push_en = 1'b1; push_id = cur;
          end
          pull_en  = 1'b1; pull_id = nx;
          st_d[nx] = pbts_pkg::SL_RUNNING;
          run_d    = nx;
        end
      end

      pbts_pkg::SQ_DONE: begin
        if (out_free) begin
          rt_ext = made_v_q ? {4'b0, made_q} : {4'b0, run_q};
          pr_ext = {4'b0, prior_q};
          mx     = {16'b0, miss_q};
          out_v_d = 1'b1;
          out_d.status         = sts_q;
          out_d.result_task    = rt_ext[3:0];
          out_d.switched       = run_q != prior_q;
          out_d.prior_task     = pr_ext[3:0];
          out_d.resched_needed = (st_q[cur] != pbts_pkg::SL_RUNNING) ||
                                 (bv_q && bp_q < eff_q[cur]);
          out_d.miss_mask      = mx[15:0];
          out_d.none_ready     = none_q;
        end
      end

      default: ;
    endcase
  end

  // Run-order ranks: a push enters at rank 0 and ages the others, a pull
  // closes the gap above the leaving task.
  always_comb begin
    logic [TW:0] r;
    for (int j = 0; j < TASK_SLOTS; j++) begin
      r = {1'b0, rank_q[j]};
      if (st_q[j] == pbts_pkg::SL_READY) begin
        if (push_en) r = r + 1'b1;
        if (pull_en && rank_q[j] > rank_q[pull_id]) r = r - 1'b1;
      end
      rank_d[j] = r[TW-1:0];
      if (push_en && push_id == TW'(j)) rank_d[j] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int j = 0; j < TASK_SLOTS; j++) begin
        st_q[j]   <= (j == 0) ? pbts_pkg::SL_RUNNING : pbts_pkg::SL_UNUSED;
        base_q[j] <= (j == 0) ? clamp_prio(pbts_pkg::IDLE_PRIO_RST) : '0;
        eff_q[j]  <= (j == 0) ? clamp_prio(pbts_pkg::IDLE_PRIO_RST) : '0;
        pol_q[j]  <= pbts_pkg::POL_FIFO;
        left_q[j] <= '0;
        full_q[j] <= '0;
        wake_q[j] <= '0;
        due_q[j]  <= '0;
        per_q[j]  <= '0;
        rank_q[j] <= '0;
      end
      run_q    <= '0;
      tick_q   <= '0;
      en_q     <= pbts_pkg::SCHED_EN_RST;
      slice_q  <= pbts_pkg::SLICE_RST;
      sts_q    <= pbts_pkg::STS_OK;
      made_v_q <= 1'b0;
      none_q   <= 1'b0;
      bv_q     <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      st_q   <= st_d;   base_q <= base_d; eff_q  <= eff_d;  pol_q <= pol_d;
      left_q <= left_d; full_q <= full_d; wake_q <= wake_d; due_q <= due_d;
      per_q  <= per_d;  rank_q <= rank_d;
      run_q    <= run_d;
      tick_q   <= tick_d;
      en_q     <= en_d;
      slice_q  <= slice_d;
      sts_q    <= sts_d;
      made_v_q <= made_v_d;
      none_q   <= none_d;
      bv_q     <= bv_d;
      out_v_q  <= out_v_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    prior_q <= prior_d;
    made_q  <= made_d;
    miss_q  <= miss_d;
    bid_q   <= bid_d;
    bp_q    <= bp_d;
    br_q    <= br_d;
    out_q   <= out_d;
  end

endmodule
